FILE: src/pcidlru_pkg.sv
`timescale 1ns / 1ps

package pcidlru_pkg;

  localparam int SLOTS_DEF      = 8;
  localparam int FRAME_BITS_DEF = 40;

  localparam int ROOT_W      = 40;
  localparam int SLOT_W      = 3;
  localparam int CR3_W       = 64;
  localparam int STAMP_W     = 64;
  localparam int PCID_W      = 12;
  localparam int PAGE_SHIFT  = 12;
  localparam int NO_FLUSH_BIT = 63;

  typedef struct packed {
    logic load;
    logic first;
  } scan_ctrl_t;

endpackage

FILE: src/pcidlru_ram.sv
`timescale 1ns / 1ps

module pcidlru_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/pcidlru_scan.sv
`timescale 1ns / 1ps

module pcidlru_scan #(
  parameter int SLOTS      = pcidlru_pkg::SLOTS_DEF,
  parameter int FRAME_BITS = pcidlru_pkg::FRAME_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  pcidlru_pkg::scan_ctrl_t                   ctrl_i,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] idx_i,
  input  logic [FRAME_BITS-1:0]                     key_i,
  input  logic                                      rd_valid_i,
  input  logic [pcidlru_pkg::STAMP_W-1:0]           rd_stamp_i,
  input  logic [FRAME_BITS-1:0]                     rd_frame_i,
  output logic                                      match_o,
  output logic                                      hit_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] hit_idx_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] victim_idx_o,
  output logic                                      victim_valid_o,
  output logic [FRAME_BITS-1:0]                     victim_frame_o
);
  import pcidlru_pkg::*;

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic                hit_q, hit_d;
  logic [IdxW-1:0]     hit_idx_q, hit_idx_d;
  logic [IdxW-1:0]     vidx_q, vidx_d;
  logic                vvalid_q, vvalid_d;
  logic [FRAME_BITS-1:0] vframe_q, vframe_d;
  logic [STAMP_W-1:0]  vstamp_q, vstamp_d;
  logic                match;

  assign match = rd_valid_i && (rd_frame_i == key_i);

  always_comb begin
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    vidx_d    = vidx_q;
    vvalid_d  = vvalid_q;
    vframe_d  = vframe_q;
    vstamp_d  = vstamp_q;
    if (ctrl_i.load) begin
      if (ctrl_i.first) begin
        hit_d = 1'b0;
      end
      if (match) begin
        hit_d     = 1'b1;
        hit_idx_d = idx_i;
      end else if (ctrl_i.first || (rd_stamp_i < vstamp_q)) begin
        vidx_d   = idx_i;
        vvalid_d = rd_valid_i;
        vframe_d = rd_frame_i;
        vstamp_d = rd_stamp_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q <= hit_idx_d;
    vidx_q    <= vidx_d;
    vvalid_q  <= vvalid_d;
    vframe_q  <= vframe_d;
    vstamp_q  <= vstamp_d;
  end

  assign match_o        = match;
  assign hit_o          = hit_q;
  assign hit_idx_o      = hit_idx_q;
  assign victim_idx_o   = vidx_q;
  assign victim_valid_o = vvalid_q;
  assign victim_frame_o = vframe_q;

endmodule

FILE: src/pcid_lru_binding_select_core.sv
`timescale 1ns / 1ps

// PCID binding slot selector. Raise start with root_frame_i while busy is low;
// the block then reads one slot per cycle from its slot memory (valid, frame,
// last-use stamp), stops at the first matching slot, after the last slot, or
// after slot 0 when pcid_enable is 0, and in its finish state writes back
// the stamp unless it hit the slot it last wrote. Its result word appears on
// the result ports for exactly one cycle, flagged by result_valid_o, in the
// same cycle that busy falls. The receiver cannot stall: the word must be
// taken in that cycle. After reset the slot memory is cleared one entry per
// cycle, with busy held high until every entry is clear; pcid_enable may be
// written meanwhile.

module pcid_lru_binding_select_core #(
  parameter int SLOTS      = pcidlru_pkg::SLOTS_DEF,
  parameter int FRAME_BITS = pcidlru_pkg::FRAME_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             pcid_enable_we_i,
  input  logic                             pcid_enable_i,
  input  logic                             start,
  output logic                             busy,
  input  logic [pcidlru_pkg::ROOT_W-1:0]   root_frame_i,
  output logic                             result_valid_o,
  output logic [pcidlru_pkg::SLOT_W-1:0]   slot_o,
  output logic                             hit_o,
  output logic                             write_cr3_o,
  output logic [pcidlru_pkg::CR3_W-1:0]    cr3_value_o,
  output logic                             evicted_valid_o,
  output logic [pcidlru_pkg::ROOT_W-1:0]   evicted_frame_o
);
  import pcidlru_pkg::*;

  localparam int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WordW = 1 + STAMP_W + FRAME_BITS;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [IdxW-1:0]     clr_q, clr_d;
  logic [FRAME_BITS-1:0] frame_q, frame_d;
  logic                pcid_en_q, pcid_en_d;
  logic [STAMP_W-1:0]  stamp_q, stamp_d;
  logic                prim_valid_q, prim_valid_d;
  logic [IdxW-1:0]     prim_slot_q, prim_slot_d;

  logic                res_valid_q, res_valid_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic                hit_q, hit_d;
  logic                wcr3_q, wcr3_d;
  logic [CR3_W-1:0]    cr3_q, cr3_d;
  logic                ev_valid_q, ev_valid_d;
  logic [ROOT_W-1:0]   ev_frame_q, ev_frame_d;

  logic                accept;
  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  logic [WordW-1:0]    mem_wdata;
  logic [IdxW-1:0]     mem_raddr;
  logic [WordW-1:0]    mem_rdata;

  scan_ctrl_t          scan_ctrl;
  logic                sc_match;
  logic                sc_hit;
  logic [IdxW-1:0]     sc_hit_idx;
  logic [IdxW-1:0]     sc_victim_idx;
  logic                sc_victim_valid;
  logic [FRAME_BITS-1:0] sc_victim_frame;

  logic [IdxW-1:0]     chosen;
  logic                is_primary;
  logic                scan_done;
  logic [CR3_W-1:0]    cr3_base;

  pcidlru_ram #(
    .Width (WordW),
    .Depth (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pcidlru_scan #(
    .SLOTS      (SLOTS),
    .FRAME_BITS (FRAME_BITS)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (scan_ctrl),
    .idx_i          (idx_q),
    .key_i          (frame_q),
    .rd_valid_i     (mem_rdata[WordW-1]),
    .rd_stamp_i     (mem_rdata[WordW-2 -: STAMP_W]),
    .rd_frame_i     (mem_rdata[FRAME_BITS-1:0]),
    .match_o        (sc_match),
    .hit_o          (sc_hit),
    .hit_idx_o      (sc_hit_idx),
    .victim_idx_o   (sc_victim_idx),
    .victim_valid_o (sc_victim_valid),
    .victim_frame_o (sc_victim_frame)
  );

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  assign scan_ctrl.load  = (state_q == ST_SCAN);
  assign scan_ctrl.first = (idx_q == '0);

  assign scan_done  = sc_match || !pcid_en_q || (idx_q == LastIdx);
  assign chosen     = sc_hit ? sc_hit_idx : sc_victim_idx;
  assign is_primary = sc_hit && prim_valid_q && (prim_slot_q == chosen);
  assign cr3_base   = (CR3_W'(frame_q) << PAGE_SHIFT) | CR3_W'(PCID_W'(chosen));

  assign mem_we    = (state_q == ST_CLEAR) || ((state_q == ST_FINISH) && !is_primary);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : chosen;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : {1'b1, stamp_q, frame_q};
  assign mem_raddr = (state_q == ST_SCAN) ? (idx_q + IdxW'(1)) : '0;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    clr_d        = clr_q;
    frame_d      = frame_q;
    pcid_en_d    = pcid_enable_we_i ? pcid_enable_i : pcid_en_q;
    stamp_d      = stamp_q;
    prim_valid_d = prim_valid_q;
    prim_slot_d  = prim_slot_q;
    res_valid_d  = 1'b0;
    slot_d       = slot_q;
    hit_d        = hit_q;
    wcr3_d       = wcr3_q;
    cr3_d        = cr3_q;
    ev_valid_d   = ev_valid_q;
    ev_frame_d   = ev_frame_q;

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + IdxW'(1);
        if (clr_q == LastIdx) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          frame_d = FRAME_BITS'(root_frame_i);
          idx_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_FINISH;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_FINISH: begin
        res_valid_d = 1'b1;
        slot_d      = SLOT_W'(chosen);
        hit_d       = sc_hit;
        wcr3_d      = !is_primary;
        ev_valid_d  = !sc_hit && sc_victim_valid;
        ev_frame_d  = (!sc_hit && sc_victim_valid) ? ROOT_W'(sc_victim_frame) : '0;
        if (is_primary) begin
          cr3_d = '0;
        end else begin
          cr3_d = cr3_base;
          if (sc_hit && pcid_en_q) begin
            cr3_d[NO_FLUSH_BIT] = 1'b1;
          end
          stamp_d      = stamp_q + STAMP_W'(1);
          prim_valid_d = 1'b1;
          prim_slot_d  = chosen;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      idx_q        <= '0;
      clr_q        <= '0;
      pcid_en_q    <= 1'b0;
      stamp_q      <= STAMP_W'(1);
      prim_valid_q <= 1'b0;
      prim_slot_q  <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      clr_q        <= clr_d;
      pcid_en_q    <= pcid_en_d;
      stamp_q      <= stamp_d;
      prim_valid_q <= prim_valid_d;
      prim_slot_q  <= prim_slot_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q    <= frame_d;
    slot_q     <= slot_d;
    hit_q      <= hit_d;
    wcr3_q     <= wcr3_d;
    cr3_q      <= cr3_d;
    ev_valid_q <= ev_valid_d;
    ev_frame_q <= ev_frame_d;
  end

  assign result_valid_o  = res_valid_q;
  assign slot_o          = slot_q;
  assign hit_o           = hit_q;
  assign write_cr3_o     = wcr3_q;
  assign cr3_value_o     = cr3_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_frame_o = ev_frame_q;

`ifndef NO_ASSERTIONS
  a_finish_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |=> result_valid_o)
    else $error("result word missing after finish");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == ST_SCAN) && (idx_q == '0))
    else $error("accepted word did not start a scan");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(hit_o && evicted_valid_o))
    else $error("hit reported together with an eviction");

  a_skip_only_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !write_cr3_o) |-> (hit_o && (cr3_value_o == '0)))
    else $error("skipped CR3 load without a primary hit");
`endif

endmodule

FILE: verif/tb_pcid_lru_binding_select_core.sv
`timescale 1ns / 1ps

module tb_pcid_lru_binding_select_core;
  import pcidlru_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_WORDS = 145;
  localparam logic [ROOT_W-1:0] FRAME_MASK = {ROOT_W{1'b1}} >> (ROOT_W - FRAME_BITS_DEF);
  localparam logic [ROOT_W-1:0] ALL_ONES = {ROOT_W{1'b1}};

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              write_cr3;
    logic [CR3_W-1:0]  cr3_value;
    logic              evicted_valid;
    logic [ROOT_W-1:0] evicted_frame;
  } binding_word_t;

  class binding_scoreboard;
    bit                pcid_on;
    bit                slot_used [SLOTS];
    logic [ROOT_W-1:0] slot_frame [SLOTS];
    bit [STAMP_W-1:0]  slot_age [SLOTS];
    bit [STAMP_W-1:0]  stamp_next;
    bit                prim_valid;
    int unsigned       prim_slot;
    binding_word_t     expected_bindings [$];
    int                errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_frame[i] = '0;
        slot_age[i] = '0;
      end
      stamp_next = 1;
      prim_valid = 1'b0;
      prim_slot = 0;
      pcid_on = 1'b0;
      errors = 0;
    endfunction

    function logic [CR3_W-1:0] cr3_word(logic [ROOT_W-1:0] frame, int unsigned s);
      logic [PCID_W-1:0] pcid;
      pcid = s[PCID_W-1:0];
      return (CR3_W'(frame) << PAGE_SHIFT) | CR3_W'(pcid);
    endfunction

    function void promote(int unsigned s);
      slot_age[s] = stamp_next;
      stamp_next = stamp_next + 1;
      prim_valid = 1'b1;
      prim_slot = s;
    endfunction

    function void note_activation(logic [ROOT_W-1:0] root);
      logic [ROOT_W-1:0] frame;
      int unsigned       victim;
      int unsigned       chosen;
      bit                found;
      binding_word_t     w;
      frame = root & FRAME_MASK;
      victim = 0;
      chosen = 0;
      found = 1'b0;
      w = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && slot_frame[i] == frame) begin
          found = 1'b1;
          chosen = i;
          break;
        end
        if (!pcid_on) break;
        if (slot_age[i] < slot_age[victim]) victim = i;
      end
      if (found) begin
        w.hit = 1'b1;
        if (!(prim_valid && prim_slot == chosen)) begin
          w.write_cr3 = 1'b1;
          w.cr3_value = cr3_word(frame, chosen);
          if (pcid_on) w.cr3_value[NO_FLUSH_BIT] = 1'b1;
          promote(chosen);
        end
      end else begin
        chosen = victim;
        if (slot_used[chosen]) begin
          w.evicted_valid = 1'b1;
          w.evicted_frame = slot_frame[chosen];
        end
        slot_used[chosen] = 1'b1;
        slot_frame[chosen] = frame;
        w.write_cr3 = 1'b1;
        w.cr3_value = cr3_word(frame, chosen);
        promote(chosen);
      end
      w.slot = chosen[SLOT_W-1:0];
      expected_bindings.insert(expected_bindings.size(), w);
    endfunction

    task report_mismatch(string what, logic [CR3_W-1:0] got, logic [CR3_W-1:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_binding(binding_word_t got);
      binding_word_t want;
      if (expected_bindings.size() == 0) begin
        report_mismatch("unexpected word", CR3_W'(got.slot), '0);
        return;
      end
      want = expected_bindings[0];
      expected_bindings.delete(0);
      if (got.slot !== want.slot) report_mismatch("slot", CR3_W'(got.slot), CR3_W'(want.slot));
      if (got.hit !== want.hit) report_mismatch("hit", CR3_W'(got.hit), CR3_W'(want.hit));
      if (got.write_cr3 !== want.write_cr3)
        report_mismatch("write_cr3", CR3_W'(got.write_cr3), CR3_W'(want.write_cr3));
      if (got.cr3_value !== want.cr3_value)
        report_mismatch("cr3_value", got.cr3_value, want.cr3_value);
      if (got.evicted_valid !== want.evicted_valid)
        report_mismatch("evicted_valid", CR3_W'(got.evicted_valid), CR3_W'(want.evicted_valid));
      if (got.evicted_frame !== want.evicted_frame)
        report_mismatch("evicted_frame", CR3_W'(got.evicted_frame), CR3_W'(want.evicted_frame));
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              pcid_enable_we_i = 1'b0;
  logic              pcid_enable_i = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [ROOT_W-1:0] root_frame_i = '0;
  logic              result_valid_o;
  logic [SLOT_W-1:0] slot_o;
  logic              hit_o;
  logic              write_cr3_o;
  logic [CR3_W-1:0]  cr3_value_o;
  logic              evicted_valid_o;
  logic [ROOT_W-1:0] evicted_frame_o;

  binding_scoreboard sb;
  int                idle_cycles = 0;

  pcid_lru_binding_select_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pcid_enable_we_i(pcid_enable_we_i),
    .pcid_enable_i   (pcid_enable_i),
    .start           (start),
    .busy            (busy),
    .root_frame_i    (root_frame_i),
    .result_valid_o  (result_valid_o),
    .slot_o          (slot_o),
    .hit_o           (hit_o),
    .write_cr3_o     (write_cr3_o),
    .cr3_value_o     (cr3_value_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_frame_o (evicted_frame_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_binding({slot_o, hit_o, write_cr3_o, cr3_value_o, evicted_valid_o,
                        evicted_frame_o});
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_pcid_lru_binding_select_core: errors");
        $finish;
      end
    end
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ROOT_W-1:0] rand_frame();
    return ROOT_W'({$urandom, $urandom});
  endfunction

  task automatic send_word(logic [ROOT_W-1:0] frame, int gap);
    root_frame_i <= frame;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_activation(frame);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_bindings.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_pcid(bit on);
    pcid_enable_we_i <= 1'b1;
    pcid_enable_i <= on;
    @(posedge clk_i);
    pcid_enable_we_i <= 1'b0;
    sb.pcid_on = on;
  endtask

  initial begin
    logic [ROOT_W-1:0] pool [16];
    int                pool_n;
    int                r;
    bit                no_idle;
    logic [ROOT_W-1:0] frame;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_pcid(1'b0);

    // single slot: fill, hit primary, evict twice
    send_word('0, rand_gap());
    send_word('0, rand_gap());
    send_word(ALL_ONES, rand_gap());
    send_word(40'h5555555555, rand_gap());
    drain();
    set_pcid(1'b1);
    send_word(40'h5555555555, rand_gap());
    send_word(40'h0000000001, rand_gap());
    send_word(40'hAAAAAAAAAA, rand_gap());
    send_word(40'h8000000000, rand_gap());
    send_word(rand_frame(), rand_gap());
    send_word(rand_frame(), rand_gap());
    send_word(rand_frame(), rand_gap());
    send_word(ALL_ONES, rand_gap());
    send_word(40'h5555555555, rand_gap());
    send_word('0, rand_gap());
    send_word(40'hAAAAAAAAAA, rand_gap());
    send_word(40'hAAAAAAAAAA, rand_gap());
    drain();
    // other slots stay bound while only slot 0 is used
    set_pcid(1'b0);
    send_word(40'h8000000000, rand_gap());
    send_word(40'h8000000000, rand_gap());
    drain();
    set_pcid(1'b1);
    send_word(40'h8000000000, rand_gap());
    send_word(40'h5555555555, rand_gap());
    send_word(ALL_ONES, rand_gap());
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_pcid(ph[0] ? 1'b0 : 1'b1);
      pool_n = (ph < 2) ? 9 : $urandom_range(2, 16);
      no_idle = (ph == 3 || ph == 6);
      for (int k = 0; k < pool_n; k++) begin
        r = $urandom_range(0, 9);
        pool[k] = (r == 0) ? '0 : (r == 1) ? ALL_ONES : rand_frame();
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 80) frame = pool[$urandom_range(0, pool_n - 1)];
        else if (r < 95) frame = rand_frame();
        else if (r < 97) frame = '0;
        else if (r < 99) frame = ALL_ONES;
        else frame = ROOT_W'(1) << $urandom_range(0, ROOT_W - 1);
        send_word(frame, no_idle ? 0 : rand_gap());
        if (n == PHASE_WORDS / 2 && ph == 4) drain();
      end
      drain();
    end

    repeat (SLOTS * 4) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_bindings.size() == 0) begin
      $display("tb_pcid_lru_binding_select_core: clean");
    end else begin
      $display("tb_pcid_lru_binding_select_core: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/pcidlru_pkg.sv
src/pcidlru_ram.sv
src/pcidlru_scan.sv
src/pcid_lru_binding_select_core.sv
verif/tb_pcid_lru_binding_select_core.sv
